>>> rtl/skrf_pkg.sv
// Shared types and constants for the scalar Kalman range filter.
// No dependencies; imported by skrf_div and scalar_kalman_range_filter.
package skrf_pkg;

   // Fixed-point formats: variances UQ2.30, gain UQ1.30, estimate UQ16.16.
   localparam int FRAC_BITS = 30;
   localparam int VAR_BITS = 32;
   localparam int EST_BITS = 32;
   localparam int SAMPLE_W = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int DUTY_W = 8;

   // Divider geometry: the gain quotient needs 31 bits, the duty quotient 8.
   localparam int DIV_Q_BITS = 31;
   localparam int DIV_REM_BITS = 33;
   localparam int DIV_CNT_BITS = 5;
   localparam int DUTY_DIV_STEPS = 8;

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PROCESS_NOISE = 8'd0,
      REG_MEASURE_NOISE = 8'd1,
      REG_RANGE_LOW     = 8'd2,
      REG_RANGE_HIGH    = 8'd3
   } csr_reg_type;

   localparam logic [VAR_BITS-1:0] PROCESS_NOISE_RESET = 32'd1073742;
   localparam logic [VAR_BITS-1:0] MEASURE_NOISE_RESET = 32'd536870912;
   localparam logic [SAMPLE_W-1:0] RANGE_LOW_RESET = 16'd0;
   localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RESET = 16'd4000;
   localparam logic [VAR_BITS-1:0] VARIANCE_RESET = 32'h4000_0000;
   localparam logic [DIV_Q_BITS-1:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

   typedef struct packed {
      logic                      start;
      logic [DIV_CNT_BITS-1:0]   steps;
      logic [DIV_REM_BITS-1:0]   rem_init;
      logic [DIV_Q_BITS-1:0]     dividend_lo;
      logic [DIV_REM_BITS-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                      busy;
      logic                      done;
      logic [DIV_Q_BITS-1:0]     quotient;
   } div_rsp_type;

endpackage

>>> rtl/scalar_kalman_range_filter.sv
// Top level of the scalar Kalman range filter: sequencer, state and registers.
// Depends on skrf_pkg, skrf_div and skrf_mul.
//
//   channel | ports                                   | direction
//   req     | req_valid, req_stall, req_sample        | sample in
//   rsp     | rsp_valid, rsp_stall, rsp_smoothed/duty | result out
//   csr     | csr_valid, csr_ready, csr_index/data    | register write
//
// The first sample after reset only seeds the estimate and gives no result.
// Every later sample runs through the divider for the gain, two passes through
// the multiplier for the estimate and variance, and a second division for the
// duty byte when it is neither zero nor capped, before its result is offered.
// req_stall stays high from acceptance until the result transaction completes.
// Reset is synchronous and restores the registers and the filter state.
module scalar_kalman_range_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [skrf_pkg::SAMPLE_W-1:0]        req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [skrf_pkg::SAMPLE_W-1:0]        rsp_smoothed,
   output logic [skrf_pkg::DUTY_W-1:0]          rsp_duty,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [skrf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [skrf_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import skrf_pkg::*;

   localparam logic [SAMPLE_W-1:0] SampleMask = (SAMPLE_BITS >= SAMPLE_W) ?
      {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVK,
      ST_MULK,
      ST_EST,
      ST_VAR,
      ST_DUTY,
      ST_DIVD,
      ST_OUT
   } state_type;

   state_type             state_ff;
   logic [VAR_BITS-1:0]   process_noise_ff;
   logic [VAR_BITS-1:0]   measure_noise_ff;
   logic [SAMPLE_W-1:0]   range_low_ff;
   logic [SAMPLE_W-1:0]   range_high_ff;
   logic [EST_BITS-1:0]   estimate_ff;
   logic [VAR_BITS-1:0]   variance_ff;
   logic                  seeded_ff;
   logic [SAMPLE_W-1:0]   z_ff;
   logic [VAR_BITS-1:0]   p1_ff;
   logic                  den_zero_ff;
   logic [DIV_Q_BITS-1:0] k_ff;
   logic                  neg_ff;
   logic [SAMPLE_W-1:0]   smoothed_ff;
   logic [DUTY_W-1:0]     duty_ff;
   logic                  rsp_valid_ff;

   logic [SAMPLE_W-1:0]   z_in;
   logic [VAR_BITS:0]     p1_sum;
   logic [VAR_BITS-1:0]   p1_in;
   logic [VAR_BITS:0]     den;
   logic [EST_BITS-1:0]   zf;
   logic                  neg_in;
   logic [EST_BITS-1:0]   mag;
   logic [EST_BITS-1:0]   corr;
   logic [EST_BITS:0]     est_sub;
   logic [EST_BITS:0]     est_add;
   logic [DIV_Q_BITS-1:0] one_minus_k;
   logic [SAMPLE_W:0]     dl;
   logic [SAMPLE_W:0]     span;
   logic [SAMPLE_W-1:0]   dl_mag;
   logic [SAMPLE_W-1:0]   span_mag;
   logic [SAMPLE_W+DUTY_W-1:0] duty_num;
   logic                  duty_zero;
   logic                  duty_cap;
   logic [31:0]           mul_a;
   logic [31:0]           mul_b;
   logic [63:0]           mul_prod;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   skrf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   skrf_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   // Configuration registers; indexes beyond the list are ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         process_noise_ff <= PROCESS_NOISE_RESET;
         measure_noise_ff <= MEASURE_NOISE_RESET;
         range_low_ff <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_PROCESS_NOISE: process_noise_ff <= csr_data[VAR_BITS-1:0];
            REG_MEASURE_NOISE: measure_noise_ff <= csr_data[VAR_BITS-1:0];
            REG_RANGE_LOW:     range_low_ff <= csr_data[SAMPLE_W-1:0];
            REG_RANGE_HIGH:    range_high_ff <= csr_data[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Kalman datapath pieces.
   assign z_in = req_sample & SampleMask;
   assign p1_sum = {1'b0, variance_ff} + {1'b0, process_noise_ff};
   assign p1_in = p1_sum[VAR_BITS] ? {VAR_BITS{1'b1}} : p1_sum[VAR_BITS-1:0];
   assign den = {1'b0, p1_ff} + {1'b0, measure_noise_ff};
   assign zf = {z_ff, 16'b0};
   assign neg_in = zf < estimate_ff;
   assign mag = neg_in ? (estimate_ff - zf) : (zf - estimate_ff);
   assign corr = mul_prod[FRAC_BITS+EST_BITS-1:FRAC_BITS];
   assign est_sub = {1'b0, estimate_ff} - {1'b0, corr};
   assign est_add = {1'b0, estimate_ff} + {1'b0, corr};
   assign one_minus_k = ONE_Q30 - k_ff;

   // Duty mapping works on magnitudes; a negative quotient clamps to zero,
   // and a quotient of 255 or more is caught before dividing.
   assign dl = {1'b0, z_ff} - {1'b0, range_low_ff};
   assign span = {1'b0, range_high_ff} - {1'b0, range_low_ff};
   assign dl_mag = dl[SAMPLE_W] ? SAMPLE_W'(-dl) : dl[SAMPLE_W-1:0];
   assign span_mag = span[SAMPLE_W] ? SAMPLE_W'(-span) : span[SAMPLE_W-1:0];
   assign duty_num = {dl_mag, DUTY_W'(0)} - {DUTY_W'(0), dl_mag};
   assign duty_zero = (span_mag == '0) || (dl[SAMPLE_W] ^ span[SAMPLE_W]);
   assign duty_cap = dl_mag >= span_mag;

   always_comb begin
      if (state_ff == ST_MULK) begin
         mul_a = {1'b0, k_ff};
         mul_b = mag;
      end else begin
         mul_a = {1'b0, one_minus_k};
         mul_b = p1_ff;
      end
   end

   always_comb begin
      div_req.start = (state_ff == ST_LOAD) ||
                      ((state_ff == ST_DUTY) && !duty_zero && !duty_cap);
      if (state_ff == ST_LOAD) begin
         div_req.steps = DIV_CNT_BITS'(DIV_Q_BITS);
         div_req.rem_init = {2'b0, p1_ff[VAR_BITS-1:1]};
         div_req.dividend_lo = {p1_ff[0], {FRAC_BITS{1'b0}}};
         div_req.divisor = den;
      end else begin
         div_req.steps = DIV_CNT_BITS'(DUTY_DIV_STEPS);
         div_req.rem_init = {{(DIV_REM_BITS-SAMPLE_W){1'b0}},
                             duty_num[SAMPLE_W+DUTY_W-1:DUTY_W]};
         div_req.dividend_lo = {duty_num[DUTY_W-1:0], {(DIV_Q_BITS-DUTY_W){1'b0}}};
         div_req.divisor = {{(DIV_REM_BITS-SAMPLE_W){1'b0}}, span_mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         estimate_ff <= '0;
         variance_ff <= VARIANCE_RESET;
         seeded_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (!seeded_ff) begin
                     estimate_ff <= {z_in, 16'b0};
                     seeded_ff <= 1'b1;
                  end else begin
                     z_ff <= z_in;
                     p1_ff <= p1_in;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               den_zero_ff <= (den == '0);
               state_ff <= ST_DIVK;
            end
            ST_DIVK: begin
               if (div_rsp.done) begin
                  k_ff <= den_zero_ff ? '0 : div_rsp.quotient;
                  state_ff <= ST_MULK;
               end
            end
            ST_MULK: begin
               neg_ff <= neg_in;
               state_ff <= ST_EST;
            end
            ST_EST: begin
               if (neg_ff) begin
                  estimate_ff <= est_sub[EST_BITS] ? '0 : est_sub[EST_BITS-1:0];
               end else begin
                  estimate_ff <= est_add[EST_BITS] ? {EST_BITS{1'b1}} :
                                 est_add[EST_BITS-1:0];
               end
               state_ff <= ST_VAR;
            end
            ST_VAR: begin
               variance_ff <= mul_prod[FRAC_BITS+VAR_BITS-1:FRAC_BITS];
               smoothed_ff <= estimate_ff[EST_BITS-1:EST_BITS-SAMPLE_W];
               state_ff <= ST_DUTY;
            end
            ST_DUTY: begin
               if (duty_zero) begin
                  duty_ff <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else if (duty_cap) begin
                  duty_ff <= DUTY_MAX;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_DIVD;
               end
            end
            ST_DIVD: begin
               if (div_rsp.done) begin
                  duty_ff <= div_rsp.quotient[DUTY_W-1:0];
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_smoothed = smoothed_ff;
   assign rsp_duty = duty_ff;

`ifndef NO_ASSERTIONS
   // A pending result must hold off the next sample.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("sample accepted while a result is pending");

   // The divider only reports completion while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVK || state_ff == ST_DIVD))
      else $error("divider finished outside a divide state");

   // The gain never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MULK |-> k_ff <= ONE_Q30)
      else $error("gain above one");

   // The updated variance never exceeds the predicted variance.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_VAR |=> variance_ff <= $past(p1_ff))
      else $error("variance grew during the update");
`endif

endmodule

>>> rtl/skrf_mul.sv
// Registered 32 x 32 unsigned multiplier shared by the estimate and variance updates.
// Depends on nothing; the product is valid in the cycle after its operands.
module skrf_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] mul_prod
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = {32'b0, mul_a} * {32'b0, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

>>> rtl/skrf_div.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on skrf_pkg for the request and response structs.
module skrf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  skrf_pkg::div_req_type div_req,
   output skrf_pkg::div_rsp_type div_rsp
);
   import skrf_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CNT_BITS-1:0] count_ff;
   logic [DIV_REM_BITS-1:0] rem_ff;
   logic [DIV_REM_BITS-1:0] rem_in;
   logic [DIV_Q_BITS-1:0]   lo_ff;
   logic [DIV_REM_BITS-1:0] divisor_ff;
   logic [DIV_Q_BITS-1:0]   quot_ff;
   logic [DIV_REM_BITS:0]   trial;
   logic [DIV_REM_BITS:0]   diff;
   logic                    fits;

   // The remainder stays below the divisor, so the borrow bit of the
   // trial subtraction alone decides the quotient bit.
   assign trial = {rem_ff, lo_ff[DIV_Q_BITS-1]};
   assign diff = trial - {1'b0, divisor_ff};
   assign fits = !diff[DIV_REM_BITS];
   assign rem_in = fits ? diff[DIV_REM_BITS-1:0] : trial[DIV_REM_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            count_ff <= div_req.steps;
         end else if (busy_ff) begin
            count_ff <= count_ff - DIV_CNT_BITS'(1);
            if (count_ff == DIV_CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= div_req.rem_init;
         lo_ff <= div_req.dividend_lo;
         divisor_ff <= div_req.divisor;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         lo_ff <= {lo_ff[DIV_Q_BITS-2:0], 1'b0};
         quot_ff <= {quot_ff[DIV_Q_BITS-2:0], fits};
      end
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

>>> verif/tb_scalar_kalman_range_filter.sv
// Self-checking testbench for scalar_kalman_range_filter: directed and random samples
// are checked against a fixed-point Kalman predictor kept in the testbench.
// Depends on skrf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_scalar_kalman_range_filter;
   import skrf_pkg::*;

   localparam int RUN_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 60;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_PHASES = 12;
   localparam int SAMPLES_PER_PHASE = 100;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_INDEX = 8'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOP_INDEX = 8'hFF;
   localparam logic [63:0] GAIN_UNITY = 64'd1 << FRAC_BITS;
   localparam logic [VAR_BITS-1:0] NOISE_MAX = 32'hFFFF_FFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

   typedef struct packed {
      logic [SAMPLE_W-1:0] smoothed;
      logic [DUTY_W-1:0]   duty;
   } reading_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [SAMPLE_W-1:0]       req_sample;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [SAMPLE_W-1:0]       rsp_smoothed;
   logic [DUTY_W-1:0]         rsp_duty;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   // Register copies and filter state of the predictor.
   logic [VAR_BITS-1:0] q_noise;
   logic [VAR_BITS-1:0] r_noise;
   logic [SAMPLE_W-1:0] span_low;
   logic [SAMPLE_W-1:0] span_high;
   logic [EST_BITS-1:0] est_q16;
   logic [VAR_BITS-1:0] var_q30;
   bit                  seeded;

   reading_type pending_readings[$];
   int          mismatches;
   int          cycle_count;
   bit          quiet;

   scalar_kalman_range_filter dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_smoothed (rsp_smoothed),
      .rsp_duty     (rsp_duty),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("tb_scalar_kalman_range_filter NOT OK");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one; none at all in quiet phases.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [DUTY_W-1:0] duty_for(logic [SAMPLE_W-1:0] z);
      longint lo;
      longint hi;
      longint zl;
      longint v;
      lo = span_low;
      hi = span_high;
      zl = z;
      if (hi == lo) return '0;
      v = (zl - lo) * 255 / (hi - lo);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[DUTY_W-1:0];
   endfunction

   // One filter step; returns 1 when the sample produces a reading.
   function automatic bit kalman_predict(input logic [SAMPLE_W-1:0] z,
                                         output reading_type r);
      logic [63:0] p1;
      logic [63:0] den;
      logic [63:0] gain;
      logic [63:0] zf;
      logic [63:0] est64;
      logic [63:0] mag;
      logic [63:0] corr;
      logic [63:0] var_next;
      longint      est_next;
      bit          neg;
      r = '0;
      if (!seeded) begin
         est_q16 = {z, 16'h0000};
         seeded = 1'b1;
         return 1'b0;
      end
      p1 = var_q30;
      p1 = p1 + q_noise;
      if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
      den = p1 + r_noise;
      gain = (den == 0) ? 64'd0 : (p1 << FRAC_BITS) / den;
      zf = z;
      zf = zf << 16;
      est64 = est_q16;
      neg = zf < est64;
      mag = neg ? est64 - zf : zf - est64;
      corr = (gain * mag) >> FRAC_BITS;
      est_next = neg ? longint'(est64) - longint'(corr) : longint'(est64) + longint'(corr);
      if (est_next < 0) est_next = 0;
      if (est_next > 64'sd4294967295) est_next = 64'sd4294967295;
      est_q16 = est_next[EST_BITS-1:0];
      var_next = ((GAIN_UNITY - gain) * p1) >> FRAC_BITS;
      var_q30 = var_next[VAR_BITS-1:0];
      r.smoothed = est_q16[EST_BITS-1:16];
      r.duty = duty_for(z);
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s expected %0d, got %0d", cycle_count, what, want, got);
   endtask

   always @(posedge clock) begin : check_reading
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("unexpected reading, smoothed", -1, rsp_smoothed);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_smoothed !== want.smoothed)
               report_mismatch("smoothed", want.smoothed, rsp_smoothed);
            if (rsp_duty !== want.duty)
               report_mismatch("duty", want.duty, rsp_duty);
         end
      end
   end

   // Result side back-pressure.
   initial begin : drive_rsp_stall
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = pick_gap();
         if (n > 0) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end
         @(negedge clock) rsp_stall <= 1'b0;
      end
   end

   // Offers one sample and returns at the edge where the transaction completes.
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int          gap;
      reading_type r;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_sample <= SAMPLE_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      if (kalman_predict(s, r)) pending_readings.push_back(r);
   endtask

   // Lowers valid and lets every outstanding reading drain before a register write.
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_PROCESS_NOISE: q_noise = data;
         REG_MEASURE_NOISE: r_noise = data;
         REG_RANGE_LOW:     span_low = data[SAMPLE_W-1:0];
         REG_RANGE_HIGH:    span_high = data[SAMPLE_W-1:0];
         default: ;
      endcase
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic set_filter(input logic [VAR_BITS-1:0] q, input logic [VAR_BITS-1:0] r,
                             input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi);
      wait_idle();
      write_csr(REG_PROCESS_NOISE, q);
      write_csr(REG_MEASURE_NOISE, r);
      write_csr(REG_RANGE_LOW, {16'h0000, lo});
      write_csr(REG_RANGE_HIGH, {16'h0000, hi});
   endtask

   // The first sample only seeds the estimate; the rest run with reset settings.
   task automatic test_seed_and_defaults();
      send_sample(SAMPLE_MAX);
      send_sample(16'd0);
      send_sample(SAMPLE_MAX);
      send_sample(RANGE_HIGH_RESET);
      send_sample(16'd0);
   endtask

   task automatic test_duty_mapping();
      set_filter(PROCESS_NOISE_RESET, MEASURE_NOISE_RESET, 16'd1000, 16'd3000);
      send_sample(16'd0);
      send_sample(16'd1000);
      send_sample(16'd2000);
      send_sample(16'd3000);
      send_sample(SAMPLE_MAX);
      // Reversed bounds invert the mapping before the clamp.
      set_filter(PROCESS_NOISE_RESET, MEASURE_NOISE_RESET, 16'd3000, 16'd1000);
      send_sample(16'd500);
      send_sample(16'd2000);
      send_sample(16'd3500);
      // Equal bounds always give zero duty.
      set_filter(PROCESS_NOISE_RESET, MEASURE_NOISE_RESET, 16'd500, 16'd500);
      send_sample(16'd500);
      send_sample(16'd12345);
      set_filter(PROCESS_NOISE_RESET, MEASURE_NOISE_RESET, 16'd0, SAMPLE_MAX);
      send_sample(16'd0);
      send_sample(SAMPLE_MAX);
   endtask

   task automatic test_noise_extremes();
      // Largest Q saturates the predicted variance.
      set_filter(NOISE_MAX, NOISE_MAX, 16'd0, SAMPLE_MAX);
      send_sample(16'd40000);
      send_sample(16'd100);
      // With R at zero the gain is one and the variance collapses to zero.
      set_filter(NOISE_MAX, '0, 16'd0, SAMPLE_MAX);
      send_sample(16'd30000);
      // Zero variance with zero Q and R makes the gain denominator zero.
      set_filter('0, '0, RANGE_LOW_RESET, RANGE_HIGH_RESET);
      send_sample(16'd60000);
      send_sample(16'd7);
      // Writes to indexes past the last register must leave everything alone.
      wait_idle();
      write_csr(REG_SPARE_INDEX, NOISE_MAX);
      write_csr(REG_TOP_INDEX, NOISE_MAX);
      send_sample(16'd2500);
      set_filter(PROCESS_NOISE_RESET, MEASURE_NOISE_RESET, RANGE_LOW_RESET, RANGE_HIGH_RESET);
      send_sample(16'd1234);
   endtask

   task automatic test_random_phases();
      logic [VAR_BITS-1:0] q;
      logic [VAR_BITS-1:0] r;
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
      logic [SAMPLE_W-1:0] swap;
      int                  cur;
      int                  roll;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0: q = '0;
            1: q = NOISE_MAX;
            2: q = $urandom;
            default: q = $urandom_range(1, 1 << 24);
         endcase
         case ($urandom_range(0, 5))
            0: r = '0;
            1: r = NOISE_MAX;
            2: r = $urandom;
            default: r = $urandom_range(1 << 20, 1 << 31);
         endcase
         lo = SAMPLE_W'($urandom_range(0, 30000));
         hi = lo + SAMPLE_W'($urandom_range(1, 35535));
         case ($urandom_range(0, 7))
            0: begin
               swap = lo;
               lo = hi;
               hi = swap;
            end
            1: hi = lo;
            2: begin
               lo = '0;
               hi = SAMPLE_MAX;
            end
            default: ;
         endcase
         set_filter(q, r, lo, hi);
         quiet = (phase % 4 == 3);
         cur = $urandom_range(0, 65535);
         for (int i = 0; i < SAMPLES_PER_PHASE; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
               // A target that drifts by a random step of up to 400 either way.
               cur = cur + $urandom_range(0, 800) - 400;
               if (cur < 0) cur = 0;
               if (cur > 65535) cur = 65535;
            end else if (roll < 90) begin
               cur = $urandom_range(0, 65535);
            end else begin
               cur = ($urandom_range(0, 1) == 1) ? 65535 : 0;
            end
            send_sample(cur[SAMPLE_W-1:0]);
         end
         quiet = 1'b0;
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cycle_count = 0;
      mismatches = 0;
      quiet = 1'b0;
      q_noise = PROCESS_NOISE_RESET;
      r_noise = MEASURE_NOISE_RESET;
      span_low = RANGE_LOW_RESET;
      span_high = RANGE_HIGH_RESET;
      est_q16 = '0;
      var_q30 = VARIANCE_RESET;
      seeded = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_seed_and_defaults();
      test_duty_mapping();
      test_noise_extremes();
      test_random_phases();

      wait_idle();
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("tb_scalar_kalman_range_filter OK");
      end else begin
         $display("tb_scalar_kalman_range_filter NOT OK");
      end
      $finish;
   end

endmodule
